### src/rqk_pkg.sv
package rqk_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH_TAIL = 2'd0,
        REQ_PUSH_HEAD = 2'd1,
        REQ_REMOVE    = 2'd2,
        REQ_PEEK      = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    localparam int unsigned REQ_W    = 2;
    localparam int unsigned PID_W    = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned HEAD_W   = 8;
    localparam int unsigned COUNT_W  = 5;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic cap;   // latch compare result for the accepted item
        logic exec;  // apply the latched request this cycle
        t_req req;
        logic room;  // queue not full
    } t_cell_ctl;

endpackage

### src/rqk_if.sv
interface rqk_in_if;
    logic                       valid;
    logic                       ready;
    logic [rqk_pkg::REQ_W-1:0]  req_type;
    logic [rqk_pkg::PID_W-1:0]  process_id;

    modport source (output valid, output req_type, output process_id, input ready);
    modport sink   (input valid, input req_type, input process_id, output ready);
endinterface

interface rqk_out_if;
    logic                          valid;
    logic                          ready;
    logic [rqk_pkg::STATUS_W-1:0]  status;
    logic [rqk_pkg::HEAD_W-1:0]    head_id;
    logic [rqk_pkg::COUNT_W-1:0]   entry_count;

    modport source (output valid, output status, output head_id, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input head_id, input entry_count,
                    output ready);
endinterface

### src/rqk_cell.sv
module rqk_cell #(
    parameter int unsigned ID_WIDTH  = 8,
    parameter int unsigned CNT_WIDTH = 5,
    parameter int unsigned IDX       = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rqk_pkg::t_cell_ctl     i_ctl,
    input  logic [CNT_WIDTH-1:0]   i_count,
    input  logic [ID_WIDTH-1:0]    i_cmp_id,
    input  logic [ID_WIDTH-1:0]    i_load_id,
    input  logic [ID_WIDTH-1:0]    i_prev_val,
    input  logic [ID_WIDTH-1:0]    i_next_val,
    input  logic                   i_hit_before,
    output logic                   o_hit_thru,
    output logic [ID_WIDTH-1:0]    o_val,
    output logic [ID_WIDTH-1:0]    o_n_val
);
    import rqk_pkg::*;

    localparam logic [CNT_WIDTH-1:0] IDX_C = CNT_WIDTH'(IDX);

    logic [ID_WIDTH-1:0] r_val;
    logic                r_hit;
    logic [ID_WIDTH-1:0] n_val;
    logic                in_use;

    assign in_use     = IDX_C < i_count;
    assign o_hit_thru = i_hit_before | r_hit;
    assign o_val      = r_val;
    assign o_n_val    = n_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.exec) begin
            case (i_ctl.req)
                REQ_PUSH_TAIL: begin
                    if (i_ctl.room && (IDX_C == i_count)) n_val = i_load_id;
                end
                REQ_PUSH_HEAD: begin
                    if (i_ctl.room) n_val = i_prev_val;
                end
                REQ_REMOVE: begin
                    if (o_hit_thru) n_val = i_next_val;
                end
                default: n_val = r_val;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.cap) begin
            r_hit <= in_use && (r_val == i_cmp_id);
        end
    end

endmodule

### src/ready_queue_with_keyed_removal_unit.sv
// Ready queue with keyed removal, built as a chain of QUEUE_DEPTH entry cells.
// The compare is latched on the input accept; the shift and result update follow in the execute
// state, which waits while an untaken result is pending; no new item is accepted until it is done.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// entry contents are not cleared.
module ready_queue_with_keyed_removal_unit #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned ID_WIDTH    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rqk_in_if.sink      i_req,
    rqk_out_if.source   o_rsp
);
    import rqk_pkg::*;

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    t_state               r_state, n_state;
    t_req                 r_req;
    logic [ID_WIDTH-1:0]  r_id;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_out_valid;
    t_status              r_status, n_status;
    logic [HEAD_W-1:0]    r_head, n_head;

    t_cell_ctl            ctl;
    logic                 accept, exec, found;
    logic [ID_WIDTH-1:0]  cmp_id;
    logic [ID_WIDTH+PID_W-1:0]  pid_ext;
    logic [ID_WIDTH+HEAD_W-1:0] head_ext;
    logic [CW+COUNT_W-1:0]      cnt_ext;

    logic [ID_WIDTH-1:0]  val   [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]  n_val [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] hit;

    assign pid_ext = {{ID_WIDTH{1'b0}}, i_req.process_id};
    assign cmp_id  = pid_ext[ID_WIDTH-1:0];
    assign accept  = i_req.valid && i_req.ready;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        exec        = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!r_out_valid || o_rsp.ready) begin
                    exec    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign ctl.cap  = accept;
    assign ctl.exec = exec;
    assign ctl.req  = r_req;
    assign ctl.room = r_count < DEPTH_C;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= t_req'(i_req.req_type);
            r_id  <= cmp_id;
        end
    end

    // cell chain
    assign hit[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic [ID_WIDTH-1:0] prev_v, next_v;
            if (g == 0) begin : g_first
                assign prev_v = r_id;
            end else begin : g_mid
                assign prev_v = val[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign next_v = '0;
            end else begin : g_inner
                assign next_v = val[g+1];
            end
            rqk_cell #(
                .ID_WIDTH  (ID_WIDTH),
                .CNT_WIDTH (CW),
                .IDX       (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_count      (r_count),
                .i_cmp_id     (cmp_id),
                .i_load_id    (r_id),
                .i_prev_val   (prev_v),
                .i_next_val   (next_v),
                .i_hit_before (hit[g]),
                .o_hit_thru   (hit[g+1]),
                .o_val        (val[g]),
                .o_n_val      (n_val[g])
            );
        end
    endgenerate

    assign found = hit[QUEUE_DEPTH];

    // result
    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        case (r_req)
            REQ_PUSH_TAIL, REQ_PUSH_HEAD: begin
                if (ctl.room) n_count = r_count + ONE_C;
                else          n_status = ST_FULL;
            end
            REQ_REMOVE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (found) begin
                    n_count = r_count - ONE_C;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            REQ_PEEK: begin
                if (r_count == '0) n_status = ST_EMPTY;
            end
            default: n_status = ST_OK;
        endcase
    end

    assign head_ext = {{HEAD_W{1'b0}}, n_val[0]};
    assign n_head   = (n_count != '0) ? head_ext[HEAD_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_status <= n_status;
            r_head   <= n_head;
        end
    end

    assign cnt_ext           = {{COUNT_W{1'b0}}, r_count};
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.head_id     = r_head;
    assign o_rsp.entry_count = cnt_ext[COUNT_W-1:0];

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("occupancy above depth");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> o_rsp.valid)
        else $error("no result after execute");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted item not executed");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (r_status == ST_FULL)) |-> (r_count == DEPTH_C))
        else $error("full status while queue not full");

endmodule
